// ===== src/kse_pkg.sv =====
// ============================================================================
// kse_pkg: shared types and constants for the scalar Kalman estimator
// Fixed-point widths, reset values, register indexes, control word format
// and the control program of the sequencer.
// ============================================================================
`default_nettype none

package kse_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int FRAC_BITS           = 12;   // Q10.12 estimate
    localparam int EST_W               = 22;
    localparam int VAR_W               = 20;
    localparam int GAIN_W              = 17;
    localparam int SUM_W               = VAR_W + 1;
    localparam int PVAR_W              = GAIN_W + VAR_W;

    localparam logic [EST_W-1:0]  EST_MAX  = {EST_W{1'b1}};
    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'd65536;
    localparam int                HALF_Q16 = 32768;

    localparam logic [VAR_W-1:0] SENSOR_VARIANCE_RESET = 20'd1311;
    localparam logic [EST_W-1:0] START_ESTIMATE_RESET  = 22'd3891200;
    localparam logic [VAR_W-1:0] START_VARIANCE_RESET  = 20'd58982;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = EST_W;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_VARIANCE = 2'd0,
        CFG_START_ESTIMATE  = 2'd1,
        CFG_START_VARIANCE  = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_idx_t;

    // divider: one leading quotient bit, then one bit per step while the
    // count runs from DIV_REPEATS down to zero (sixteen steps)
    localparam int               DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_REPEATS = 4'd15;

    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_SUM       = 3'd1,
        OP_DIV_FIRST = 3'd2,
        OP_DIV_STEP  = 3'd3,
        OP_GAIN      = 3'd4,
        OP_MUL_D     = 3'd5,
        OP_MUL_P     = 3'd6,
        OP_UPDATE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_NO_INPUT = 2'd1,
        COND_DIV_MORE = 2'd2,
        COND_OUT_BUSY = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        STEP_WAIT      = 3'd0,
        STEP_SUM       = 3'd1,
        STEP_DIV_FIRST = 3'd2,
        STEP_DIV_STEP  = 3'd3,
        STEP_GAIN      = 3'd4,
        STEP_MUL_D     = 3'd5,
        STEP_MUL_P     = 3'd6,
        STEP_UPDATE    = 3'd7
    } step_t;

    // hold: suppress the operation while the jump condition is true
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic en;
    } dp_ctrl_t;

    typedef struct packed {
        logic div_more;
    } dp_status_t;

    // Control program; the last step falls through to the first by wrap.
    function automatic ucode_t ucode(input step_t s);
        ucode_t w;
        unique case (s)
            STEP_WAIT:      w = '{OP_LOAD,      COND_NO_INPUT, 1'b1, STEP_WAIT};
            STEP_SUM:       w = '{OP_SUM,       COND_NONE,     1'b0, STEP_WAIT};
            STEP_DIV_FIRST: w = '{OP_DIV_FIRST, COND_NONE,     1'b0, STEP_WAIT};
            STEP_DIV_STEP:  w = '{OP_DIV_STEP,  COND_DIV_MORE, 1'b0, STEP_DIV_STEP};
            STEP_GAIN:      w = '{OP_GAIN,      COND_NONE,     1'b0, STEP_WAIT};
            STEP_MUL_D:     w = '{OP_MUL_D,     COND_NONE,     1'b0, STEP_WAIT};
            STEP_MUL_P:     w = '{OP_MUL_P,     COND_NONE,     1'b0, STEP_WAIT};
            STEP_UPDATE:    w = '{OP_UPDATE,    COND_OUT_BUSY, 1'b1, STEP_UPDATE};
            default:        w = '{OP_LOAD,      COND_NO_INPUT, 1'b1, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/kse_datapath.sv =====
// ============================================================================
// kse_datapath: arithmetic and state of the scalar Kalman estimator
// Holds estimate, variance and configuration; per cycle, while enabled, runs
// one sequencer op: load, sum, restoring divide, gain, two multiplies, update.
// ============================================================================
`default_nettype none

module kse_datapath
    import kse_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_ctrl_t               ctrl,
    output dp_status_t                  status,
    input  wire logic [SAMPLE_BITS-1:0] measurement,
    input  wire logic                   restart,
    input  wire logic                   cfg_we,
    input  wire cfg_idx_t               cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [EST_W-1:0]            filtered_estimate,
    output logic [GAIN_W-1:0]           gain,
    output logic [VAR_W-1:0]            new_variance
);

    localparam int ZW = SAMPLE_BITS + FRAC_BITS;
    localparam int DW = (ZW > EST_W) ? ZW : EST_W;
    localparam int PW = GAIN_W + DW;

    logic [VAR_W-1:0]       r_reg,       r_next;
    logic [EST_W-1:0]       x0_reg,      x0_next;
    logic [VAR_W-1:0]       p0_reg,      p0_next;
    logic [EST_W-1:0]       x_reg,       x_next;
    logic [VAR_W-1:0]       p_reg,       p_next;
    logic [SAMPLE_BITS-1:0] meas_reg,    meas_next;
    logic [SUM_W-1:0]       sum_reg,     sum_next;
    logic [SUM_W-1:0]       rem_reg,     rem_next;
    logic [GAIN_W-1:0]      q_reg,       q_next;
    logic [GAIN_W-1:0]      g_reg,       g_next;
    logic [DW-1:0]          mag_reg,     mag_next;
    logic                   neg_reg,     neg_next;
    logic [DIV_CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [PW-1:0]          prod_d_reg,  prod_d_next;
    logic [PVAR_W-1:0]      prod_p_reg,  prod_p_next;
    logic [EST_W-1:0]       oest_reg,    oest_next;
    logic [GAIN_W-1:0]      ogain_reg,   ogain_next;
    logic [VAR_W-1:0]       ovar_reg,    ovar_next;

    logic [DW-1:0]    z_ext;
    logic [DW-1:0]    x_ext;
    logic [SUM_W:0]   rem_sh;
    logic [SUM_W:0]   rem_diff;
    logic             rem_ge;
    logic [PW:0]      rnd_d;
    logic [DW+1:0]    delta;
    logic [DW+2:0]    up_sum;
    logic [DW+1:0]    dn_diff;
    logic [EST_W-1:0] est_new;
    logic [PVAR_W:0]  rnd_p;

    always_comb
    begin
        z_ext = DW'(meas_reg) << FRAC_BITS;
        x_ext = DW'(x_reg);

        // first quotient bit compares P itself, later bits shift in a zero
        rem_sh   = (ctrl.op == OP_DIV_FIRST) ? (SUM_W+1)'(p_reg)
                                             : {rem_reg, 1'b0};
        rem_diff = rem_sh - (SUM_W+1)'(sum_reg);
        rem_ge   = (rem_sh >= (SUM_W+1)'(sum_reg));

        rnd_d   = (PW+1)'(prod_d_reg) + (PW+1)'(HALF_Q16);
        delta   = rnd_d[PW:16];
        up_sum  = (DW+3)'(x_reg) + (DW+3)'(delta);
        dn_diff = (DW+2)'(x_reg) - delta;
        if (neg_reg)
        begin
            est_new = (delta > (DW+2)'(x_reg)) ? '0 : dn_diff[EST_W-1:0];
        end
        else
        begin
            est_new = (up_sum > (DW+3)'(EST_MAX)) ? EST_MAX : up_sum[EST_W-1:0];
        end
        // (1-g)P < 2^36, so the rounded result always fits the variance width
        rnd_p = (PVAR_W+1)'(prod_p_reg) + (PVAR_W+1)'(HALF_Q16);
    end

    always_comb
    begin
        r_next      = r_reg;
        x0_next     = x0_reg;
        p0_next     = p0_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        meas_next   = meas_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        g_next      = g_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        prod_d_next = prod_d_reg;
        prod_p_next = prod_p_reg;
        oest_next   = oest_reg;
        ogain_next  = ogain_reg;
        ovar_next   = ovar_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SENSOR_VARIANCE: r_next  = cfg_data[VAR_W-1:0];
                CFG_START_ESTIMATE:  x0_next = cfg_data[EST_W-1:0];
                CFG_START_VARIANCE:  p0_next = cfg_data[VAR_W-1:0];
                default:             ;
            endcase
        end

        if (ctrl.en)
        begin
            unique case (ctrl.op)
                OP_LOAD:
                begin
                    meas_next = measurement;
                    if (restart)
                    begin
                        x_next = x0_reg;
                        p_next = p0_reg;
                    end
                end
                OP_SUM:
                begin
                    sum_next = SUM_W'(p_reg) + SUM_W'(r_reg);
                    neg_next = (z_ext < x_ext);
                    mag_next = (z_ext < x_ext) ? (x_ext - z_ext) : (z_ext - x_ext);
                end
                OP_DIV_FIRST:
                begin
                    rem_next = rem_ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
                    q_next   = {{(GAIN_W-1){1'b0}}, rem_ge};
                    cnt_next = DIV_REPEATS;
                end
                OP_DIV_STEP:
                begin
                    rem_next = rem_ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
                    q_next   = {q_reg[GAIN_W-2:0], rem_ge};
                    cnt_next = cnt_reg - 1'b1;
                end
                OP_GAIN:
                begin
                    g_next = (sum_reg == '0) ? '0 : q_reg;
                end
                OP_MUL_D:
                begin
                    prod_d_next = PW'(g_reg) * PW'(mag_reg);
                end
                OP_MUL_P:
                begin
                    prod_p_next = PVAR_W'(ONE_Q16 - g_reg) * PVAR_W'(p_reg);
                end
                OP_UPDATE:
                begin
                    x_next     = est_new;
                    p_next     = rnd_p[VAR_W+15:16];
                    oest_next  = est_new;
                    ogain_next = g_reg;
                    ovar_next  = rnd_p[VAR_W+15:16];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= SENSOR_VARIANCE_RESET;
            x0_reg  <= START_ESTIMATE_RESET;
            p0_reg  <= START_VARIANCE_RESET;
            x_reg   <= START_ESTIMATE_RESET;
            p_reg   <= START_VARIANCE_RESET;
            cnt_reg <= '0;
        end
        else
        begin
            r_reg   <= r_next;
            x0_reg  <= x0_next;
            p0_reg  <= p0_next;
            x_reg   <= x_next;
            p_reg   <= p_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        g_reg      <= g_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        prod_d_reg <= prod_d_next;
        prod_p_reg <= prod_p_next;
        oest_reg   <= oest_next;
        ogain_reg  <= ogain_next;
        ovar_reg   <= ovar_next;
    end

    assign status.div_more   = (cnt_reg != '0);
    assign filtered_estimate = oest_reg;
    assign gain              = ogain_reg;
    assign new_variance      = ovar_reg;

endmodule

`default_nettype wire

// ===== src/scalar_kalman_static_estimator.sv =====
// ============================================================================
// scalar_kalman_static_estimator: scalar Kalman filter for a constant value
// Microcoded sequencer over a shared datapath; one result per sample.
// ============================================================================
// Each sample runs through the control program of the sequencer in order:
// the step that takes the item, P+R and |z-x|, the gain division (one
// quotient bit per cycle in the restoring divider), fixing the gain, the
// two multiplies and the update of the state. The result sits in an output
// register; the next sample can be accepted in the cycle after the update
// and runs while the result waits, and only its update step stalls if the
// previous result has not yet been taken.
// Configuration writes are always ready; a new sensor variance applies from
// the next sample, new start values reach the running state at the next
// restart.
`default_nettype none

module scalar_kalman_static_estimator
    import kse_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // s_tdata: measurement [SAMPLE_BITS-1:0], zero fill above
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser: restart [0]
    input  wire logic [0:0]                           s_tuser,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // m_tdata: filtered_estimate [21:0], gain [38:22], new_variance [58:39]
    output logic [63:0]                               m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                cfg_data
);

    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    ucode_t     uword;
    logic       jump;
    dp_ctrl_t   ctrl;
    dp_status_t status;

    logic [EST_W-1:0]  filtered_estimate;
    logic [GAIN_W-1:0] gain;
    logic [VAR_W-1:0]  new_variance;

    assign uword = ucode(step_reg);

    // next step
    always_comb
    begin
        unique case (uword.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_INPUT: jump = !s_tvalid;
            COND_DIV_MORE: jump = status.div_more;
            COND_OUT_BUSY: jump = out_valid_reg && !m_tready;
            default:       jump = 1'b0;
        endcase
        step_next = jump ? uword.target : step_t'(step_reg + 3'd1);
    end

    // outputs of the sequencer
    always_comb
    begin
        ctrl.op  = uword.op;
        ctrl.en  = !(jump && uword.hold);
        s_tready = (uword.op == OP_LOAD);
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (uword.op == OP_UPDATE && ctrl.en)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    kse_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .status            (status),
        .measurement       (s_tdata[SAMPLE_BITS-1:0]),
        .restart           (s_tuser[0]),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_idx_t'(cfg_index)),
        .cfg_data          (cfg_data),
        .filtered_estimate (filtered_estimate),
        .gain              (gain),
        .new_variance      (new_variance)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, new_variance, gain, filtered_estimate};

    a_valid_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg == STEP_UPDATE))
        else $error("result raised outside the update step");

    a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step_reg == STEP_SUM))
        else $error("accepted item did not start the program");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_DIV_STEP && !status.div_more) |=> (step_reg == STEP_GAIN))
        else $error("divider did not finish after its last step");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (gain <= ONE_Q16))
        else $error("gain above one");

endmodule

`default_nettype wire

// ===== verif/scalar_kalman_static_estimator_tb.sv =====
// ============================================================================
// scalar_kalman_static_estimator_tb: self-checking bench for the estimator
// Streams ADC samples through the filter and checks each estimate, gain and
// variance against an in-bench fixed-point model of the Kalman update. Both
// stream sides idle at random, and the register set changes between phases.
// ============================================================================
`timescale 1ns / 100ps

module scalar_kalman_static_estimator_tb
    import kse_pkg::*;
();

    localparam int MEAS_W     = SAMPLE_BITS_DEFAULT;
    localparam int S_TDATA_W  = ((MEAS_W + 7) / 8) * 8;
    localparam int LONG_HOLD  = 400;
    localparam int STALL_MAX  = 4000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 100;
    localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};
    localparam logic [MEAS_W-1:0] MEAS_MAX = {MEAS_W{1'b1}};

    // packed so that a cast of m_tdata[58:0] lines up: estimate in the low bits
    typedef struct packed {
        logic [VAR_W-1:0]  variance;
        logic [GAIN_W-1:0] gain;
        logic [EST_W-1:0]  est;
    } kal_out_t;

    typedef struct {
        logic [MEAS_W-1:0] meas;
        logic              restart;
    } sample_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [63:0]            m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    scalar_kalman_static_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the filter state and registers
    logic [EST_W-1:0] est_state     = START_ESTIMATE_RESET;
    logic [VAR_W-1:0] var_state     = START_VARIANCE_RESET;
    logic [VAR_W-1:0] noise_reg     = SENSOR_VARIANCE_RESET;
    logic [EST_W-1:0] start_est_reg = START_ESTIMATE_RESET;
    logic [VAR_W-1:0] start_var_reg = START_VARIANCE_RESET;

    sample_t  pending_samples[$];
    kal_out_t expected_results[$];

    int items_sent     = 0;
    int items_taken    = 0;
    int results_taken  = 0;
    int cfg_taken      = 0;
    int failures       = 0;
    int hold_requests  = 0;
    bit no_idle        = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic kal_out_t kalman_update(input logic [EST_W-1:0] x_in,
                                               input logic [VAR_W-1:0] p_in,
                                               input logic [VAR_W-1:0] r_in,
                                               input logic [MEAS_W-1:0] meas);
        logic [63:0] z, x, p, sum, g, mag, delta, nx, np;
        logic        neg;
        kal_out_t    res;
        x = 64'(x_in);
        p = 64'(p_in);
        z = 64'(meas) << FRAC_BITS;
        sum = p + 64'(r_in);
        g = (sum == 0) ? 64'd0 : (p << 16) / sum;
        if (g > 64'(ONE_Q16))
            g = 64'(ONE_Q16);
        neg = z < x;
        mag = neg ? (x - z) : (z - x);
        delta = (g * mag + 64'(HALF_Q16)) >> 16;
        if (neg)
            nx = (delta > x) ? 64'd0 : x - delta;
        else
            nx = x + delta;
        if (nx > 64'(EST_MAX))
            nx = 64'(EST_MAX);
        np = ((64'(ONE_Q16) - g) * p + 64'(HALF_Q16)) >> 16;
        if (np > 64'(VAR_MAX))
            np = 64'(VAR_MAX);
        res.est      = nx[EST_W-1:0];
        res.gain     = g[GAIN_W-1:0];
        res.variance = np[VAR_W-1:0];
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // sample driver: gap before each item, hold the item until taken
    always @(negedge clk)
    begin : sample_driver
        logic        v;
        int unsigned gap;
        sample_t     item;
        if (rst_n)
        begin
            v = s_tvalid;
            if (v && items_taken == items_sent)
                v = 1'b0;
            if (!v)
            begin
                if (gap != 0)
                    gap--;
                else if (pending_samples.size() != 0)
                begin
                    item = pending_samples.pop_front();
                    v = 1'b1;
                    items_sent++;
                    gap = draw_gap();
                    s_tdata <= S_TDATA_W'(item.meas);
                    s_tuser <= item.restart;
                end
            end
            s_tvalid <= v;
        end
    end

    // result receiver: random wait after each item, plus an occasional long hold
    always @(negedge clk)
    begin : result_ready
        int          seen;
        int          hold_seen;
        int          hold_left;
        int unsigned wait_left;
        logic        nxt;
        if (rst_n)
        begin
            if (seen != results_taken)
            begin
                seen = results_taken;
                wait_left = draw_gap();
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (wait_left != 0)
            begin
                wait_left--;
                nxt = 1'b0;
            end
            else
                nxt = 1'b1;
            m_tready <= nxt;
        end
    end

    // monitor: track registers, predict on every accepted sample, check results
    always @(posedge clk)
    begin : monitor
        kal_out_t res;
        kal_out_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SENSOR_VARIANCE: noise_reg     = cfg_data[VAR_W-1:0];
                    CFG_START_ESTIMATE:  start_est_reg = cfg_data[EST_W-1:0];
                    CFG_START_VARIANCE:  start_var_reg = cfg_data[VAR_W-1:0];
                    default: ;
                endcase
                cfg_taken <= cfg_taken + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got = kal_out_t'(m_tdata[58:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result with no sample pending: estimate %0d", got.est);
                    failures++;
                end
                else
                begin
                    res = expected_results.pop_front();
                    if (got.est !== res.est)
                    begin
                        $error("filtered_estimate: expected %0d, got %0d", res.est, got.est);
                        failures++;
                    end
                    if (got.gain !== res.gain)
                    begin
                        $error("gain: expected %0d, got %0d", res.gain, got.gain);
                        failures++;
                    end
                    if (got.variance !== res.variance)
                    begin
                        $error("new_variance: expected %0d, got %0d",
                               res.variance, got.variance);
                        failures++;
                    end
                end
                results_taken <= results_taken + 1;
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    est_state = start_est_reg;
                    var_state = start_var_reg;
                end
                res = kalman_update(est_state, var_state, noise_reg, s_tdata[MEAS_W-1:0]);
                est_state = res.est;
                var_state = res.variance;
                expected_results.push_back(res);
                items_taken <= items_taken + 1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        int goal;
        goal = cfg_taken + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (cfg_taken != goal);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] noise,
                              input logic [CFG_DATA_W-1:0] start_est,
                              input logic [CFG_DATA_W-1:0] start_var);
        cfg_write(CFG_SENSOR_VARIANCE, noise);
        cfg_write(CFG_START_ESTIMATE, start_est);
        cfg_write(CFG_START_VARIANCE, start_var);
    endtask

    task automatic add_sample(input logic [MEAS_W-1:0] meas, input logic restart);
        sample_t s;
        s.meas = meas;
        s.restart = restart;
        pending_samples.push_back(s);
    endtask

    // idle means nothing left to send and every result back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || items_sent != items_taken
               || expected_results.size() != 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int unsigned bits);
        logic [CFG_DATA_W-1:0] mask;
        mask = CFG_DATA_W'((64'd1 << bits) - 64'd1);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return mask;
            2:       return CFG_DATA_W'($urandom_range(0, 255));
            default: return CFG_DATA_W'($urandom) & mask;
        endcase
    endfunction

    function automatic logic [MEAS_W-1:0] pick_meas();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return MEAS_MAX;
            default: return MEAS_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: zero innovation first, then field extremes
        add_sample(MEAS_W'(950), 1'b0);
        add_sample('0, 1'b0);
        add_sample(MEAS_MAX, 1'b0);
        add_sample(MEAS_MAX, 1'b1);
        add_sample(MEAS_W'(10'h2AA), 1'b0);
        add_sample(MEAS_W'(10'h155), 1'b1);
        add_sample('0, 1'b1);
        add_sample(MEAS_W'(512), 1'b0);
        wait_drained();

        // zero denominator: P and R both zero
        write_regs('0, '0, '0);
        add_sample(MEAS_MAX, 1'b1);
        add_sample(MEAS_W'(500), 1'b0);
        add_sample('0, 1'b0);
        wait_drained();

        // no sensor noise, full variance: gain of one
        write_regs('0, CFG_DATA_W'(EST_MAX), CFG_DATA_W'(VAR_MAX));
        add_sample('0, 1'b1);
        add_sample(MEAS_MAX, 1'b0);
        add_sample(MEAS_MAX, 1'b1);
        wait_drained();

        // huge noise against tiny variance: gain rounds to zero
        write_regs(CFG_DATA_W'(VAR_MAX), '0, CFG_DATA_W'(1));
        add_sample(MEAS_MAX, 1'b1);
        add_sample(MEAS_W'(10), 1'b0);
        wait_drained();

        // the spare index must leave the registers alone
        cfg_write(CFG_UNUSED, {CFG_DATA_W{1'b1}});
        write_regs(CFG_DATA_W'(VAR_MAX), CFG_DATA_W'(EST_MAX), CFG_DATA_W'(VAR_MAX));
        add_sample('0, 1'b1);
        add_sample(MEAS_MAX, 1'b0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_regs(pick_reg(VAR_W), pick_reg(EST_W), pick_reg(VAR_W));
            no_idle = (ph == 2 || ph == 6);
            add_sample(pick_meas(), 1'b1);
            for (int i = 1; i < PHASE_ITEMS; i++)
                add_sample(pick_meas(), ($urandom_range(0, 7) == 0));
            // stall the output long enough to back up the input
            if (ph == 4)
                hold_requests++;
            wait_drained();
        end
        no_idle = 1'b0;

        // catch any stray result
        repeat (60) @(posedge clk);
        @(negedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== scalar_kalman_static_estimator.f =====
src/kse_pkg.sv
src/kse_datapath.sv
src/scalar_kalman_static_estimator.sv
verif/scalar_kalman_static_estimator_tb.sv
